>>> sv/npss_pkg.sv
// Package for the nearest path segment search block.
// Holds the item structs, the controller state and command codes, and the width constants.
// No dependencies.
`default_nettype none

package npss_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int COORD_W     = 24;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int MUL_W       = DIFF_W + 1;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int SQ_W        = 2 * DIFF_W;
    localparam int DOT_W       = SQ_W + 1;
    localparam int NUM_W       = 2 * SQ_W;
    localparam int ARC_W       = 36;
    localparam int WIN_W       = 20;
    localparam int SPC_W       = 16;
    localparam int DIST_W      = 51;
    localparam int HINT_W      = 10;
    localparam int STEP_W      = IDX_W + 1;
    localparam int K_W         = 6;
    localparam int NPROD       = 13;
    localparam int PK_W        = $clog2(NPROD);
    localparam int DIV_STEPS   = SQ_W;
    localparam int SQRT_STEPS  = SQ_W / 2;
    localparam int DEGEN_LEN_SQ = 1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic CFG_SEARCH_WINDOW = 1'b0;
    localparam logic CFG_MIN_SPACING   = 1'b1;

    // Product slots of the shared multiplier.
    localparam logic [PK_W-1:0] PK_DXDX = 4'd0;
    localparam logic [PK_W-1:0] PK_DYDY = 4'd1;
    localparam logic [PK_W-1:0] PK_EXDX = 4'd2;
    localparam logic [PK_W-1:0] PK_EYDY = 4'd3;
    localparam logic [PK_W-1:0] PK_EXDY = 4'd4;
    localparam logic [PK_W-1:0] PK_EYDX = 4'd5;
    localparam logic [PK_W-1:0] PK_EXEX = 4'd6;
    localparam logic [PK_W-1:0] PK_EYEY = 4'd7;
    localparam logic [PK_W-1:0] PK_FXFX = 4'd8;
    localparam logic [PK_W-1:0] PK_FYFY = 4'd9;
    localparam logic [PK_W-1:0] PK_LL   = 4'd10;
    localparam logic [PK_W-1:0] PK_HL   = 4'd11;
    localparam logic [PK_W-1:0] PK_HH   = 4'd12;

    typedef struct packed {
        logic                      command;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      first;
        logic                      last;
        logic [HINT_W-1:0]         hint;
    } t_in_item;

    typedef struct packed {
        logic [DIST_W-1:0] dist_sq;
        logic [HINT_W-1:0] best_segment;
        logic              no_path;
        logic              kept;
        logic [CNT_W-1:0]  point_count;
        logic              overflow;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH,
        S_L_CHK, S_L_RD, S_L_DIFF, S_L_MUL, S_L_COMB, S_L_KEEP, S_L_SQRT, S_L_WRITE,
        S_Q_RD, S_Q_HD,
        S_SEG_RD, S_SEG_DIFF, S_SEG_MUL, S_SEG_COMB, S_SEG_BR, S_SEG_MULC, S_SEG_NUM,
        S_SEG_DIVI, S_SEG_DIV, S_SEG_UPDQ,
        S_BK_START, S_BK_RD, S_BK_CHK, S_FW_START, S_FW_RD, S_FW_CHK, S_FW_END,
        S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_CAPTURE, OP_LD_FIRST, OP_DIFF, OP_MUL, OP_COMB, OP_SQRT_INIT,
        OP_SQRT_STEP, OP_WRITE, OP_SET_OVF, OP_LATCH_HD, OP_NUM, OP_DIV_INIT,
        OP_DIV_STEP, OP_UPDATE, OP_NOPATH, OP_OUT
    } t_dp_op;

    typedef enum logic [1:0] {
        DSEL_D0, DSEL_D1, DSEL_Q
    } t_dsel;

    typedef struct packed {
        t_dp_op            op;
        logic [PK_W-1:0]   mul_k;
        logic [IDX_W-1:0]  pa0;
        logic [IDX_W-1:0]  pa1;
        logic [IDX_W-1:0]  arc_a;
        logic [IDX_W-1:0]  seg;
        t_dsel             dsel;
        logic              init;
    } t_dp_cmd;

    typedef struct packed {
        logic              is_query;
        logic [CNT_W-1:0]  count;
        logic [HINT_W-1:0] hint;
        logic              keep;
        logic              near_start;
        logic              past_end;
        logic              arc_lo;
        logic              arc_hi;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> sv/npss_datapath.sv
// Datapath of the nearest path segment search: point and arc length memories, the shared
// multiplier, divider and square root registers, and the result and output registers.
// Depends on npss_pkg; driven by npss_ctrl.
`default_nettype none

module npss_datapath import npss_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_in_item          i_in_data,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [WIN_W-1:0]  i_cfg_data,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_stat               o_stat,
    output t_out_item              o_out_data
);

    logic [2*COORD_W-1:0] r_mem_pt  [0:MAX_POINTS-1];
    logic [ARC_W-1:0]     r_mem_arc [0:MAX_POINTS-1];
    logic [2*COORD_W-1:0] r_rd0, r_rd1;
    logic [ARC_W-1:0]     r_arc_rd, r_hd;

    t_in_item             r_item;
    logic [CNT_W-1:0]     r_count;
    logic                 r_ovf;
    logic [WIN_W-1:0]     r_win;
    logic [2*SPC_W-1:0]   r_ms_sq;

    logic signed [DIFF_W-1:0] r_dx, r_dy, r_ex, r_ey, r_fx, r_fy;
    logic signed [PROD_W-1:0] r_prod [0:NPROD-1];
    logic [SQ_W-1:0]          r_len, r_d0, r_d1, r_cross, r_q, r_rem;
    logic signed [DOT_W-1:0]  r_dot;
    logic [NUM_W-1:0]         r_num;
    logic [SQ_W-1:0]          r_sv, r_sr, r_sbit;

    logic [DIST_W-1:0]        r_res_dist;
    logic [HINT_W-1:0]        r_res_best;
    logic                     r_res_nopath, r_res_kept;
    t_out_item                r_out;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [DOT_W-1:0]  cross_s;
    logic [SQ_W:0]            div_t;
    logic                     div_ge;
    logic [SQ_W-1:0]          sq_try;
    logic [SQ_W-1:0]          upd_d;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.mul_k)
            PK_DXDX: begin mul_a = MUL_W'(r_dx); mul_b = MUL_W'(r_dx); end
            PK_DYDY: begin mul_a = MUL_W'(r_dy); mul_b = MUL_W'(r_dy); end
            PK_EXDX: begin mul_a = MUL_W'(r_ex); mul_b = MUL_W'(r_dx); end
            PK_EYDY: begin mul_a = MUL_W'(r_ey); mul_b = MUL_W'(r_dy); end
            PK_EXDY: begin mul_a = MUL_W'(r_ex); mul_b = MUL_W'(r_dy); end
            PK_EYDX: begin mul_a = MUL_W'(r_ey); mul_b = MUL_W'(r_dx); end
            PK_EXEX: begin mul_a = MUL_W'(r_ex); mul_b = MUL_W'(r_ex); end
            PK_EYEY: begin mul_a = MUL_W'(r_ey); mul_b = MUL_W'(r_ey); end
            PK_FXFX: begin mul_a = MUL_W'(r_fx); mul_b = MUL_W'(r_fx); end
            PK_FYFY: begin mul_a = MUL_W'(r_fy); mul_b = MUL_W'(r_fy); end
            PK_LL: begin
                mul_a = $signed({1'b0, r_cross[DIFF_W-1:0]});
                mul_b = $signed({1'b0, r_cross[DIFF_W-1:0]});
            end
            PK_HL: begin
                mul_a = $signed({1'b0, r_cross[SQ_W-1:DIFF_W]});
                mul_b = $signed({1'b0, r_cross[DIFF_W-1:0]});
            end
            PK_HH: begin
                mul_a = $signed({1'b0, r_cross[SQ_W-1:DIFF_W]});
                mul_b = $signed({1'b0, r_cross[SQ_W-1:DIFF_W]});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    assign cross_s = $signed(r_prod[PK_EXDY][DOT_W-1:0]) - $signed(r_prod[PK_EYDX][DOT_W-1:0]);
    assign div_t   = {r_rem, r_num[NUM_W-1]};
    assign div_ge  = div_t >= (SQ_W+1)'(r_len);
    assign sq_try  = r_sr + r_sbit;

    always_comb begin
        unique case (i_cmd.dsel)
            DSEL_D0: upd_d = r_d0;
            DSEL_D1: upd_d = r_d1;
            DSEL_Q:  upd_d = r_q;
            default: upd_d = r_d0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd0    <= r_mem_pt[i_cmd.pa0];
        r_rd1    <= r_mem_pt[i_cmd.pa1];
        r_arc_rd <= r_mem_arc[i_cmd.arc_a];
        if (i_cmd.op == OP_WRITE) begin
            r_mem_pt[r_count[IDX_W-1:0]]  <= {r_item.x, r_item.y};
            r_mem_arc[r_count[IDX_W-1:0]] <= (r_count == '0) ? '0 :
                                             r_arc_rd + ARC_W'(r_sr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_win   <= WIN_W'(154);
            r_ms_sq <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_SEARCH_WINDOW) begin
                    r_win <= i_cfg_data;
                end else begin
                    r_ms_sq <= i_cfg_data[SPC_W-1:0] * i_cfg_data[SPC_W-1:0];
                end
            end
            if (i_cmd.op == OP_LD_FIRST && r_item.first) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (i_cmd.op == OP_WRITE) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.op == OP_SET_OVF) begin
                r_ovf <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_CAPTURE: begin
                r_item       <= i_in_data;
                r_res_dist   <= '0;
                r_res_best   <= '0;
                r_res_nopath <= 1'b0;
                r_res_kept   <= 1'b0;
            end
            OP_DIFF: begin
                r_dx <= DIFF_W'($signed(r_rd1[2*COORD_W-1:COORD_W]))
                      - DIFF_W'($signed(r_rd0[2*COORD_W-1:COORD_W]));
                r_dy <= DIFF_W'($signed(r_rd1[COORD_W-1:0]))
                      - DIFF_W'($signed(r_rd0[COORD_W-1:0]));
                r_ex <= DIFF_W'(r_item.x) - DIFF_W'($signed(r_rd0[2*COORD_W-1:COORD_W]));
                r_ey <= DIFF_W'(r_item.y) - DIFF_W'($signed(r_rd0[COORD_W-1:0]));
                r_fx <= DIFF_W'(r_item.x) - DIFF_W'($signed(r_rd1[2*COORD_W-1:COORD_W]));
                r_fy <= DIFF_W'(r_item.y) - DIFF_W'($signed(r_rd1[COORD_W-1:0]));
            end
            OP_MUL: begin
                if (i_cmd.mul_k <= PK_HH) begin
                    r_prod[i_cmd.mul_k] <= mul_p;
                end
            end
            OP_COMB: begin
                r_len   <= r_prod[PK_DXDX][SQ_W-1:0] + r_prod[PK_DYDY][SQ_W-1:0];
                r_d0    <= r_prod[PK_EXEX][SQ_W-1:0] + r_prod[PK_EYEY][SQ_W-1:0];
                r_d1    <= r_prod[PK_FXFX][SQ_W-1:0] + r_prod[PK_FYFY][SQ_W-1:0];
                r_dot   <= $signed(r_prod[PK_EXDX][DOT_W-1:0])
                         + $signed(r_prod[PK_EYDY][DOT_W-1:0]);
                r_cross <= cross_s[DOT_W-1] ? SQ_W'(-cross_s) : SQ_W'(cross_s);
            end
            OP_SQRT_INIT: begin
                r_sv   <= r_d0;
                r_sr   <= '0;
                r_sbit <= SQ_W'(1) << (SQ_W - 2);
            end
            OP_SQRT_STEP: begin
                if (r_sv >= sq_try) begin
                    r_sv <= r_sv - sq_try;
                    r_sr <= (r_sr >> 1) + r_sbit;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sbit <= r_sbit >> 2;
            end
            OP_WRITE: begin
                r_res_kept <= 1'b1;
            end
            OP_LATCH_HD: begin
                r_hd <= r_arc_rd;
            end
            OP_NUM: begin
                r_num <= (NUM_W'(r_prod[PK_HH][SQ_W-1:0]) << (2 * DIFF_W))
                       + (NUM_W'(r_prod[PK_HL][SQ_W-1:0]) << (DIFF_W + 1))
                       + NUM_W'(r_prod[PK_LL][SQ_W-1:0]);
            end
            OP_DIV_INIT: begin
                r_rem <= r_num[NUM_W-1:SQ_W];
                r_num <= {r_num[SQ_W-1:0], {SQ_W{1'b0}}};
                r_q   <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= div_ge ? SQ_W'(div_t - (SQ_W+1)'(r_len)) : div_t[SQ_W-1:0];
                r_num <= {r_num[NUM_W-2:0], 1'b0};
                r_q   <= {r_q[SQ_W-2:0], div_ge};
            end
            OP_UPDATE: begin
                if (i_cmd.init || DIST_W'(upd_d) < r_res_dist) begin
                    r_res_dist <= DIST_W'(upd_d);
                    r_res_best <= i_cmd.seg;
                end
            end
            OP_NOPATH: begin
                r_res_dist   <= DIST_W'(1) << (DIST_W - 1);
                r_res_nopath <= 1'b1;
            end
            OP_OUT: begin
                r_out.dist_sq      <= r_res_dist;
                r_out.best_segment <= r_res_best;
                r_out.no_path      <= r_res_nopath;
                r_out.kept         <= r_res_kept;
                r_out.point_count  <= r_count;
                r_out.overflow     <= r_ovf;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_stat.is_query   = (r_item.command == CMD_QUERY);
        o_stat.count      = r_count;
        o_stat.hint       = r_item.hint;
        o_stat.keep       = r_item.last || (r_ms_sq == '0) || (r_d0 >= SQ_W'(r_ms_sq));
        o_stat.near_start = (r_len <= SQ_W'(DEGEN_LEN_SQ)) || (r_dot <= 0);
        o_stat.past_end   = r_dot >= $signed({1'b0, r_len});
        o_stat.arc_lo     = ((ARC_W+1)'(r_arc_rd) + (ARC_W+1)'(r_win)) < (ARC_W+1)'(r_hd);
        o_stat.arc_hi     = (ARC_W+1)'(r_arc_rd) > ((ARC_W+1)'(r_hd) + (ARC_W+1)'(r_win));
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

>>> sv/npss_ctrl.sv
// Controller of the nearest path segment search: the sequencing state machine, the
// window search indices and the output valid flag.
// Depends on npss_pkg; commands npss_datapath.
`default_nettype none

module npss_ctrl import npss_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state             r_state, n_state;
    logic [K_W-1:0]     r_k, n_k;
    logic [IDX_W-1:0]   r_i, n_i, r_t, n_t, r_h, n_h, r_last, n_last;
    logic [IDX_W-1:0]   r_start, n_start, r_end, n_end;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_scan, n_scan;
    logic               r_out_valid;

    logic               slot_free;
    logic [CNT_W-1:0]   cnt_m1, cnt_m2;
    logic [IDX_W-1:0]   bk_base, fw_base, bk_t, fw_t;
    logic [STEP_W-1:0]  nx_step;
    logic [STEP_W:0]    fw_sum;
    logic               chk_state;

    assign slot_free = !r_out_valid || i_out_ready;
    assign cnt_m1    = i_stat.count - CNT_W'(1);
    assign cnt_m2    = i_stat.count - CNT_W'(2);
    assign chk_state = (r_state == S_BK_CHK) || (r_state == S_FW_CHK);
    assign nx_step   = chk_state ? {r_step[STEP_W-2:0], 1'b0} : STEP_W'(1);
    assign bk_base   = (r_state == S_BK_CHK) ? r_t : r_h;
    assign fw_base   = (r_state == S_FW_CHK) ? r_t : r_h;
    assign bk_t      = (STEP_W'(bk_base) > nx_step) ? IDX_W'(STEP_W'(bk_base) - nx_step) : '0;
    assign fw_sum    = (STEP_W+1)'(fw_base) + (STEP_W+1)'(nx_step);
    assign fw_t      = (fw_sum < (STEP_W+1)'(r_last)) ? fw_sum[IDX_W-1:0] : r_last;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_i     = r_i;
        n_t     = r_t;
        n_h     = r_h;
        n_last  = r_last;
        n_start = r_start;
        n_end   = r_end;
        n_step  = r_step;
        n_scan  = r_scan;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!i_stat.is_query) begin
                    n_state = S_L_CHK;
                end else if (i_stat.count < CNT_W'(2)) begin
                    n_state = S_DONE;
                end else begin
                    n_last  = cnt_m2[IDX_W-1:0];
                    n_h     = (CNT_W'(i_stat.hint) > cnt_m2) ? cnt_m2[IDX_W-1:0] :
                              i_stat.hint;
                    n_i     = n_h;
                    n_t     = n_h;
                    n_start = n_h;
                    n_scan  = 1'b0;
                    n_state = S_Q_RD;
                end
            end
            S_L_CHK: begin
                if (i_stat.count == '0) begin
                    n_state = S_L_WRITE;
                end else begin
                    n_i     = cnt_m1[IDX_W-1:0];
                    n_t     = cnt_m1[IDX_W-1:0];
                    n_state = S_L_RD;
                end
            end
            S_L_RD:   n_state = S_L_DIFF;
            S_L_DIFF: begin
                n_k     = K_W'(PK_EXEX);
                n_state = S_L_MUL;
            end
            S_L_MUL: begin
                n_k = r_k + K_W'(1);
                if (r_k == K_W'(PK_EYEY)) begin
                    n_state = S_L_COMB;
                end
            end
            S_L_COMB: n_state = S_L_KEEP;
            S_L_KEEP: begin
                n_k = '0;
                if (!i_stat.keep || i_stat.count >= CNT_W'(MAX_POINTS)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_L_SQRT;
                end
            end
            S_L_SQRT: begin
                n_k = r_k + K_W'(1);
                if (r_k == K_W'(SQRT_STEPS - 1)) begin
                    n_state = S_L_WRITE;
                end
            end
            S_L_WRITE: n_state = S_DONE;
            S_Q_RD:    n_state = S_Q_HD;
            S_Q_HD:    n_state = S_SEG_DIFF;
            S_SEG_RD:  n_state = S_SEG_DIFF;
            S_SEG_DIFF: begin
                n_k     = K_W'(PK_DXDX);
                n_state = S_SEG_MUL;
            end
            S_SEG_MUL: begin
                n_k = r_k + K_W'(1);
                if (r_k == K_W'(PK_FYFY)) begin
                    n_state = S_SEG_COMB;
                end
            end
            S_SEG_COMB: n_state = S_SEG_BR;
            S_SEG_BR, S_SEG_UPDQ: begin
                if (r_state == S_SEG_BR && !i_stat.near_start && !i_stat.past_end) begin
                    n_k     = K_W'(PK_LL);
                    n_state = S_SEG_MULC;
                end else if (!r_scan) begin
                    n_state = S_BK_START;
                end else if (r_i == r_end) begin
                    n_state = S_DONE;
                end else begin
                    n_i     = r_i + IDX_W'(1);
                    n_state = S_SEG_RD;
                end
            end
            S_SEG_MULC: begin
                n_k = r_k + K_W'(1);
                if (r_k == K_W'(PK_HH)) begin
                    n_state = S_SEG_NUM;
                end
            end
            S_SEG_NUM:  n_state = S_SEG_DIVI;
            S_SEG_DIVI: begin
                n_k     = '0;
                n_state = S_SEG_DIV;
            end
            S_SEG_DIV: begin
                n_k = r_k + K_W'(1);
                if (r_k == K_W'(DIV_STEPS - 1)) begin
                    n_state = S_SEG_UPDQ;
                end
            end
            S_BK_START: begin
                if (r_h == '0) begin
                    n_state = S_FW_START;
                end else begin
                    n_step  = nx_step;
                    n_t     = bk_t;
                    n_state = S_BK_RD;
                end
            end
            S_BK_RD: n_state = S_BK_CHK;
            S_BK_CHK: begin
                if (i_stat.arc_lo) begin
                    n_state = S_FW_START;
                end else begin
                    n_start = r_t;
                    if (r_t == '0) begin
                        n_state = S_FW_START;
                    end else begin
                        n_step  = nx_step;
                        n_t     = bk_t;
                        n_state = S_BK_RD;
                    end
                end
            end
            S_FW_START: begin
                if (r_h != '0 && r_start == r_h) begin
                    n_start = r_h - IDX_W'(1);
                end
                n_end = r_h;
                if (r_h == r_last) begin
                    n_state = S_FW_END;
                end else begin
                    n_step  = nx_step;
                    n_t     = fw_t;
                    n_state = S_FW_RD;
                end
            end
            S_FW_RD: n_state = S_FW_CHK;
            S_FW_CHK: begin
                if (i_stat.arc_hi) begin
                    n_state = S_FW_END;
                end else begin
                    n_end = r_t;
                    if (r_t == r_last) begin
                        n_state = S_FW_END;
                    end else begin
                        n_step  = nx_step;
                        n_t     = fw_t;
                        n_state = S_FW_RD;
                    end
                end
            end
            S_FW_END: begin
                if (r_h != r_last && r_end == r_h) begin
                    n_end = r_h + IDX_W'(1);
                end
                n_i     = r_start;
                n_scan  = 1'b1;
                n_state = S_SEG_RD;
            end
            S_DONE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.op    = OP_NONE;
        o_cmd.mul_k = r_k[PK_W-1:0];
        o_cmd.pa0   = r_i;
        o_cmd.pa1   = r_i + IDX_W'(1);
        o_cmd.arc_a = r_t;
        o_cmd.seg   = r_i;
        o_cmd.dsel  = DSEL_D0;
        o_cmd.init  = !r_scan;
        unique case (r_state)
            S_IDLE:     o_cmd.op = i_in_valid ? OP_CAPTURE : OP_NONE;
            S_DISPATCH: begin
                if (!i_stat.is_query) begin
                    o_cmd.op = OP_LD_FIRST;
                end else if (i_stat.count < CNT_W'(2)) begin
                    o_cmd.op = OP_NOPATH;
                end
            end
            S_L_DIFF, S_SEG_DIFF:            o_cmd.op = OP_DIFF;
            S_L_MUL, S_SEG_MUL, S_SEG_MULC:  o_cmd.op = OP_MUL;
            S_L_COMB, S_SEG_COMB:            o_cmd.op = OP_COMB;
            S_L_KEEP: begin
                if (i_stat.keep) begin
                    o_cmd.op = (i_stat.count >= CNT_W'(MAX_POINTS)) ? OP_SET_OVF :
                               OP_SQRT_INIT;
                end
            end
            S_L_SQRT:   o_cmd.op = OP_SQRT_STEP;
            S_L_WRITE:  o_cmd.op = OP_WRITE;
            S_Q_HD:     o_cmd.op = OP_LATCH_HD;
            S_SEG_BR: begin
                if (i_stat.near_start) begin
                    o_cmd.op = OP_UPDATE;
                end else if (i_stat.past_end) begin
                    o_cmd.op   = OP_UPDATE;
                    o_cmd.dsel = DSEL_D1;
                end
            end
            S_SEG_NUM:  o_cmd.op = OP_NUM;
            S_SEG_DIVI: o_cmd.op = OP_DIV_INIT;
            S_SEG_DIV:  o_cmd.op = OP_DIV_STEP;
            S_SEG_UPDQ: begin
                o_cmd.op   = OP_UPDATE;
                o_cmd.dsel = DSEL_Q;
            end
            S_DONE:     o_cmd.op = slot_free ? OP_OUT : OP_NONE;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scan      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_scan  <= n_scan;
            if (r_state == S_DONE && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_i     <= n_i;
        r_t     <= n_t;
        r_h     <= n_h;
        r_last  <= n_last;
        r_start <= n_start;
        r_end   <= n_end;
        r_step  <= n_step;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_done_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && slot_free) |=> r_out_valid)
        else $error("finished item not presented");

    a_scan_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEG_RD && r_scan) |-> (r_i >= r_start && r_i <= r_end))
        else $error("scan index outside the search window");

    a_window_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FW_END) |-> (r_end <= r_last && r_start <= r_h && r_h <= r_end))
        else $error("search window bounds out of order");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEG_DIV) |-> (r_k < K_W'(DIV_STEPS)))
        else $error("divider step count overrun");

endmodule

`default_nettype wire

>>> sv/nearest_path_segment_search_top.sv
// Top level of the nearest path segment search block.
// Joins npss_ctrl and npss_datapath; depends on npss_pkg.
//
// One item is worked on at a time; the next item is accepted while a finished result still
// waits in the output register. A load item on an empty path stores its point directly; a
// second or later point is measured against the previous one, then either dropped for
// spacing or capacity or stored with its arc length, which takes the integer square root
// of the step length. A query item with fewer than two stored points is answered as no
// path. Any other query reads and measures the hint segment, probes arc lengths backwards
// and forwards to find the search window, then scans each segment of the window; each
// measured segment whose nearest point lies inside it also runs the 50-step restoring
// divider. The single shared multiplier forms one product at a time and the divider one
// quotient bit per step. The point and arc length memories need no clearing after reset.
`default_nettype none

module nearest_path_segment_search_top import npss_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_item          i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_item              o_out_data,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [WIN_W-1:0]  i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    npss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    npss_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for nearest_path_segment_search_top: path loads and nearest segment
// queries, each result checked against an in-bench predictor of the stored path or a fixed expected value.
// Depends on npss_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;
    import npss_pkg::*;

    localparam int WATCHDOG_LIMIT = 500000;
    localparam int RANDOM_ITEMS   = 490;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item result;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_in_item          i_in_data;
    logic              o_out_valid;
    logic              i_out_ready;
    t_out_item         o_out_data;
    logic              i_cfg_we;
    logic              i_cfg_index;
    logic [WIN_W-1:0]  i_cfg_data;

    nearest_path_segment_search_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Predicted path state and register copies.
    longint      path_x [MAX_POINTS];
    longint      path_y [MAX_POINTS];
    logic [63:0] path_arc [MAX_POINTS];
    int unsigned path_len;
    bit          path_ovf;
    logic [63:0] window_reg;
    logic [63:0] spacing_reg;

    t_out_item   pending_results [$];
    t_out_item   oldest;
    int          errors;
    int          idle_cycles;
    bit          calm;
    int          stall_left;
    int          ready_roll;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] point_dist_sq(longint ax, longint ay, longint bx,
                                                  longint by);
        longint dx;
        longint dy;
        dx = ax - bx;
        dy = ay - by;
        return dx * dx + dy * dy;
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] segment_dist_sq(int unsigned s, longint px, longint py);
        longint       x0;
        longint       y0;
        longint       x1;
        longint       y1;
        longint       dx;
        longint       dy;
        longint       ex;
        longint       ey;
        longint       dot;
        longint       cr;
        logic [63:0]  len;
        logic [63:0]  ac;
        logic [127:0] num;
        x0 = path_x[s];
        y0 = path_y[s];
        x1 = path_x[s + 1];
        y1 = path_y[s + 1];
        dx = x1 - x0;
        dy = y1 - y0;
        ex = px - x0;
        ey = py - y0;
        len = dx * dx + dy * dy;
        if (len <= DEGEN_LEN_SQ) return point_dist_sq(px, py, x0, y0);
        dot = ex * dx + ey * dy;
        if (dot <= 0) return point_dist_sq(px, py, x0, y0);
        if (dot >= longint'(len)) return point_dist_sq(px, py, x1, y1);
        cr = ex * dy - ey * dx;
        ac = (cr < 0) ? -cr : cr;
        num = 128'(ac) * 128'(ac);
        num = num / 128'(len);
        return num[63:0];
    endfunction

    function automatic t_out_item path_step(t_in_item it);
        t_out_item   r;
        longint      px;
        longint      py;
        bit          keep;
        int unsigned nseg;
        int unsigned h;
        int unsigned lo;
        int unsigned hi;
        int unsigned t;
        int unsigned stride;
        int unsigned i;
        logic [63:0] hd;
        logic [63:0] best_d;
        logic [63:0] d;
        r = '0;
        px = it.x;
        py = it.y;
        if (it.command == CMD_LOAD) begin
            if (it.first) begin
                path_len = 0;
                path_ovf = 1'b0;
            end
            if (path_len == 0 || it.last || spacing_reg == 0) begin
                keep = 1'b1;
            end else begin
                keep = point_dist_sq(px, py, path_x[path_len - 1], path_y[path_len - 1])
                       >= spacing_reg * spacing_reg;
            end
            if (keep) begin
                if (path_len >= MAX_POINTS) begin
                    path_ovf = 1'b1;
                end else begin
                    path_x[path_len] = px;
                    path_y[path_len] = py;
                    if (path_len == 0) begin
                        path_arc[0] = 0;
                    end else begin
                        path_arc[path_len] = path_arc[path_len - 1] + floor_sqrt(
                            point_dist_sq(px, py, path_x[path_len - 1], path_y[path_len - 1]));
                    end
                    path_len++;
                    r.kept = 1'b1;
                end
            end
        end else if (path_len < 2) begin
            r.dist_sq = 51'd1 << 50;
            r.no_path = 1'b1;
        end else begin
            nseg = path_len - 1;
            h = it.hint;
            if (h > nseg - 1) h = nseg - 1;
            hd = path_arc[h];
            best_d = segment_dist_sq(h, px, py);
            r.best_segment = HINT_W'(h);
            lo = h;
            for (stride = 1; lo > 0; stride *= 2) begin
                t = (lo > stride) ? lo - stride : 0;
                if (path_arc[t] + window_reg < hd) break;
                lo = t;
                if (lo == 0) break;
            end
            if (h > 0 && lo > h - 1) lo = h - 1;
            hi = h;
            for (stride = 1; hi < nseg; stride *= 2) begin
                t = (hi + stride < nseg - 1) ? hi + stride : nseg - 1;
                if (path_arc[t] > hd + window_reg) break;
                hi = t;
                if (hi == nseg - 1) break;
            end
            if (h < nseg - 1 && hi < h + 1) hi = h + 1;
            for (i = lo; i <= hi; i++) begin
                d = segment_dist_sq(i, px, py);
                if (d < best_d) begin
                    best_d = d;
                    r.best_segment = HINT_W'(i);
                end
            end
            r.dist_sq = DIST_W'(best_d);
        end
        r.point_count = CNT_W'(path_len);
        r.overflow = path_ovf;
        return r;
    endfunction

    function automatic t_in_item in_item(bit cmd, logic [23:0] x, logic [23:0] y, bit f, bit l,
                                         logic [9:0] h);
        t_in_item it;
        it.command = cmd;
        it.x = x;
        it.y = y;
        it.first = f;
        it.last = l;
        it.hint = h;
        return it;
    endfunction

    function automatic t_out_item out_item(logic [50:0] d, logic [9:0] b, bit np, bit k,
                                           logic [10:0] c, bit o);
        t_out_item r;
        r.dist_sq = d;
        r.best_segment = b;
        r.no_path = np;
        r.kept = k;
        r.point_count = c;
        r.overflow = o;
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected, actual %p", $time, o_out_data);
                errors++;
            end else begin
                oldest = pending_results.pop_front();
                check_field("dist_sq", oldest.dist_sq, o_out_data.dist_sq);
                check_field("best_segment", oldest.best_segment, o_out_data.best_segment);
                check_field("no_path", oldest.no_path, o_out_data.no_path);
                check_field("kept", oldest.kept, o_out_data.kept);
                check_field("point_count", oldest.point_count, o_out_data.point_count);
                check_field("overflow", oldest.overflow, o_out_data.overflow);
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (calm) begin
            i_out_ready <= 1'b1;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 70) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b0;
                stall_left = (ready_roll < 97) ? $urandom_range(0, 3) : $urandom_range(20, 80);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send(t_in_item it, bit typed, t_out_item typed_result);
        t_out_item predicted;
        int        r;
        int        gap;
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = path_step(it);
        pending_results.insert(pending_results.size(), typed ? typed_result : predicted);
        r = $urandom_range(0, 99);
        gap = (calm || r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic index, logic [WIN_W-1:0] value);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == CFG_SEARCH_WINDOW) window_reg = value;
        else spacing_reg = value[SPC_W-1:0];
    endtask

    function automatic logic [23:0] wander(logic [23:0] c, int unsigned reach);
        if (reach == 0) return $urandom;
        return c + $urandom_range(0, 2 * reach) - reach;
    endfunction

    t_row        directed [$];
    t_out_item   none;
    logic [23:0] cx;
    logic [23:0] cy;
    logic [23:0] qx;
    logic [23:0] qy;
    int unsigned reach;
    int          sent;
    int          n;
    int          k;
    int          r;

    task automatic add_row(t_in_item it, bit typed, t_out_item res);
        t_row row;
        row.item = it;
        row.typed = typed;
        row.result = res;
        directed.insert(directed.size(), row);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_out_ready <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_SEARCH_WINDOW;
        i_cfg_data <= '0;
        errors = 0;
        idle_cycles = 0;
        stall_left = 0;
        calm = 1'b0;
        path_len = 0;
        path_ovf = 1'b0;
        window_reg = 154;
        spacing_reg = 0;
        none = '0;

        add_row(in_item(CMD_QUERY, 0, 0, 0, 0, 0), 1,
                out_item(51'd1 << 50, 0, 1, 0, 0, 0));
        add_row(in_item(CMD_LOAD, 5, 5, 0, 0, 0), 1,
                out_item(0, 0, 0, 1, 1, 0));
        add_row(in_item(CMD_LOAD, 24'h7FFFFF, 24'h800000, 1, 0, 0), 1,
                out_item(0, 0, 0, 1, 1, 0));
        add_row(in_item(CMD_QUERY, 24'h7FFFFF, 24'h7FFFFF, 1, 1, 10'h3FF), 1,
                out_item(51'd1 << 50, 0, 1, 0, 1, 0));
        add_row(in_item(CMD_LOAD, 24'h800000, 24'h7FFFFF, 0, 1, 0), 1,
                out_item(0, 0, 0, 1, 2, 0));
        add_row(in_item(CMD_QUERY, 0, 0, 0, 0, 10'h3FF), 0, none);
        add_row(in_item(CMD_QUERY, 24'h800000, 24'h800000, 0, 0, 0), 0, none);
        add_row(in_item(CMD_LOAD, 0, 0, 1, 1, 0), 1,
                out_item(0, 0, 0, 1, 1, 0));
        add_row(in_item(CMD_LOAD, 0, 0, 1, 0, 0), 1,
                out_item(0, 0, 0, 1, 1, 0));
        add_row(in_item(CMD_LOAD, 1000, 0, 0, 0, 0), 0, none);
        add_row(in_item(CMD_LOAD, 1000, 0, 0, 0, 0), 0, none);
        add_row(in_item(CMD_LOAD, 2000, 1000, 0, 1, 0), 0, none);
        add_row(in_item(CMD_LOAD, 3000, 1000, 0, 0, 0), 0, none);
        add_row(in_item(CMD_QUERY, 500, 500, 0, 0, 0), 0, none);
        add_row(in_item(CMD_QUERY, 24'hFFFF9C, 0, 0, 0, 2), 0, none);
        add_row(in_item(CMD_QUERY, 5000, 1000, 0, 0, 3), 0, none);
        add_row(in_item(CMD_QUERY, 1000, 0, 0, 0, 1), 0, none);
        add_row(in_item(CMD_QUERY, 1500, 24'hFFFED4, 0, 0, 1), 0, none);
        add_row(in_item(CMD_QUERY, 1500, 500, 1, 1, 10'h3FF), 0, none);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[j]) send(directed[j].item, directed[j].typed, directed[j].result);

        // Fill the path past capacity so that overflow is raised and held.
        write_reg(CFG_SEARCH_WINDOW, 154);
        write_reg(CFG_MIN_SPACING, 0);
        cx = 0;
        cy = 0;
        for (k = 0; k < MAX_POINTS + 6; k++) begin
            cx = wander(cx, 100);
            cy = wander(cy, 100);
            send(in_item(CMD_LOAD, cx, cy, k == 0, k == MAX_POINTS + 5, $urandom), 0, none);
        end
        for (k = 0; k < 6; k++) begin
            send(in_item(CMD_QUERY, wander(cx, 3000), wander(cy, 3000), $urandom, $urandom,
                         $urandom), 0, none);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 5) == 0);
            r = $urandom_range(0, 3);
            reach = (r == 0) ? 16 : (r == 1) ? 1024 : (r == 2) ? 65536 : 0;
            if ($urandom_range(0, 3) == 0) begin
                r = $urandom_range(0, 5);
                write_reg(CFG_SEARCH_WINDOW, (r == 0) ? 0 : (r == 1) ? 20'hFFFFF :
                          $urandom_range(0, (reach == 0 ? 20'hFFFFF : 4 * reach)));
                r = $urandom_range(0, 5);
                write_reg(CFG_MIN_SPACING, (r < 3) ? 0 : (r == 3) ? 16'hFFFF :
                          $urandom_range(0, (reach == 0 || reach > 65535) ? 65535 : reach));
            end
            r = $urandom_range(0, 9);
            n = (r < 7) ? $urandom_range(2, 12) : (r < 9) ? $urandom_range(13, 40) : 1;
            cx = (reach == 0 || $urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4095);
            cy = (reach == 0 || $urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4095);
            for (k = 0; k < n; k++) begin
                send(in_item(CMD_LOAD, cx, cy,
                             k == 0 && $urandom_range(0, 19) != 0,
                             (k == n - 1 && $urandom_range(0, 3) != 0) ||
                             $urandom_range(0, 29) == 0,
                             $urandom), 0, none);
                cx = wander(cx, reach);
                cy = wander(cy, reach);
                sent++;
            end
            n = $urandom_range(1, 8);
            for (k = 0; k < n; k++) begin
                qx = ($urandom_range(0, 7) == 0) ? $urandom : wander(cx, 4 * reach);
                qy = ($urandom_range(0, 7) == 0) ? $urandom : wander(cy, 4 * reach);
                r = $urandom_range(0, 9);
                send(in_item(r == 9 ? CMD_LOAD : CMD_QUERY, qx, qy, $urandom_range(0, 49) == 0,
                             $urandom, (r == 0) ? 10'h3FF : (r == 1) ? $urandom :
                             $urandom_range(0, 40)), 0, none);
                sent++;
            end
        end

        calm = 1'b0;
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
